@@ rtl/core/lzw_byte_compressor_unit_assert.svh @@
// Assertion macros for the LZW byte compressor unit.
// Used by lzw_byte_compressor_unit.sv; expects i_clk and i_rst_n in scope.
`ifndef LZW_BYTE_COMPRESSOR_UNIT_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LBC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lbc_pkg.sv @@
// Package for the LZW byte compressor: request structs and fixed widths.
// No dependencies; imported by lzw_byte_compressor_unit.
`timescale 1ns / 1ps

package lbc_pkg;

    localparam int DATA_W     = 8;
    localparam int CODE_W     = 12;
    localparam int BASE_CODES = 256;

    // Input request: one raw byte plus end-of-stream flag
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_req;

    // Output request: one emitted code plus final-code flag
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last_code;
    } t_out_req;

endpackage

@@ rtl/core/lzw_byte_compressor_unit.sv @@
// LZW byte compressor unit: hashed dictionary search, insert, output queue.
// Depends on lbc_pkg and lzw_byte_compressor_unit_assert.svh.
`timescale 1ns / 1ps
// Usage:
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per byte
// of the raw stream with an end-of-stream flag. The output channel
// (o_out_valid / i_out_stall / o_out_data) returns LZW codes, the final code of
// a stream marked with last_code. A byte yields zero, one or two codes.
// Search: the first byte of a stream resolves when it is taken. Any other byte
// reads its hash slot (ST_PH), then, if the slot holds a live code, reads the
// dictionary entry (ST_PN); an entry of this slot with another string moves
// the probe to the next slot. The search stops on a hit, at a slot without a
// live code, or at an entry owned by another slot.
// Each probe is two chained memory reads: slot read, then entry read.
// Output: codes enter a 4-deep output queue on the cycle the byte resolves
// and are offered on the next cycle.
// Reset: the hash index is swept to zero, one slot a cycle, across all
// 2^(CODE_BITS+1) slots (8192 at the default); o_in_stall is high meanwhile.
// Stall: the receiver may stall at will; the queue holds its codes and input
// is stalled whenever fewer than two queue entries are free.
// The dictionary restarts at code 256 after every end-of-stream byte.

`include "lzw_byte_compressor_unit_assert.svh"

module lzw_byte_compressor_unit
    import lbc_pkg::*;
#(
    parameter int CODE_BITS = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    localparam int HB         = CODE_BITS + 1;
    localparam int HASH_DEPTH = 1 << HB;
    localparam int DICT_DEPTH = (1 << CODE_BITS) - BASE_CODES;
    localparam int NA         = $clog2(DICT_DEPTH);
    localparam int NFW        = CODE_BITS + 1;
    localparam logic [NFW-1:0] NF_BASE  = NFW'(BASE_CODES);
    localparam logic [NFW-1:0] NF_LIMIT = NFW'(1 << CODE_BITS);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    typedef enum logic [3:0] {
        ST_CLR  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_PH   = 4'b0100,
        ST_PN   = 4'b1000
    } t_state;

    // Dictionary entry: string prefix, appended byte, hash slot that owns it
    typedef struct packed {
        logic [CODE_BITS-1:0] prefix;
        logic [DATA_W-1:0]    data_byte;
        logic [HB-1:0]        slot;
    } t_node;

    function automatic logic [HB-1:0] f_hash(input logic [CODE_BITS-1:0] p,
                                             input logic [DATA_W-1:0] d);
        f_hash = HB'(p) ^ (HB'(d) << (HB - DATA_W));
    endfunction

    // Control and payload registers
    t_state               r_state, n_state;
    logic [CODE_BITS-1:0] r_prefix;
    logic                 r_present;
    logic [NFW-1:0]       r_next_free;
    logic [DATA_W-1:0]    r_byte;
    logic                 r_last;
    logic [HB-1:0]        r_slot, n_slot;
    logic [CODE_BITS-1:0] r_code, n_code;
    logic [HB-1:0]        r_clr, n_clr;

    // Memories
    logic [CODE_BITS-1:0] hash_mem [HASH_DEPTH];
    t_node                node_mem [DICT_DEPTH];
    logic [CODE_BITS-1:0] r_hash_q;
    t_node                r_node_q;

    logic                 hash_re, hash_we;
    logic [HB-1:0]        hash_raddr, hash_waddr;
    logic [CODE_BITS-1:0] hash_wdata;
    logic                 node_re, node_we;
    logic [NA-1:0]        node_raddr, node_waddr;
    t_node                node_wdata;

    // Output queue
    t_out_req             r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [CNT_W-1:0]     r_cnt;

    logic                 acc, pop, in_range, genuine, key_match, room;
    logic                 fin, fin_last, res_miss, ins;
    logic [CODE_BITS-1:0] new_prefix;
    logic [1:0]           npush;
    t_out_req             p0, p1;

    assign acc = i_in_valid && !o_in_stall;
    assign pop = (r_cnt != '0) && !i_out_stall;

    assign o_in_stall  = !((r_state == ST_IDLE) && (r_cnt <= CNT_W'(FIFO_DEPTH - 2)));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rp];

    // Probe qualification: slot code is live and the entry points back to this slot
    assign in_range  = (NFW'(r_hash_q) >= NF_BASE) && (NFW'(r_hash_q) < r_next_free);
    assign genuine   = (r_node_q.slot == r_slot);
    assign key_match = (r_node_q.prefix == r_prefix) && (r_node_q.data_byte == r_byte);
    assign room      = (r_next_free < NF_LIMIT);
    assign ins       = res_miss && room;

    // Search sequencer
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_code     = r_code;
        n_clr      = r_clr;
        hash_re    = 1'b0;
        hash_raddr = f_hash(r_prefix, i_in_data.data_byte);
        hash_we    = 1'b0;
        hash_waddr = r_slot;
        hash_wdata = CODE_BITS'(r_next_free);
        node_re    = 1'b0;
        node_raddr = NA'(NFW'(r_hash_q) - NF_BASE);
        node_we    = 1'b0;
        node_waddr = NA'(r_next_free - NF_BASE);
        node_wdata = '{prefix: r_prefix, data_byte: r_byte, slot: r_slot};
        fin        = 1'b0;
        fin_last   = 1'b0;
        res_miss   = 1'b0;
        new_prefix = r_prefix;
        unique case (r_state)
            ST_CLR: begin
                hash_we    = 1'b1;
                hash_waddr = r_clr;
                hash_wdata = '0;
                n_clr      = r_clr + HB'(1);
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    if (!r_present) begin
                        // first byte of a stream becomes the prefix
                        fin        = 1'b1;
                        fin_last   = i_in_data.end_of_stream;
                        new_prefix = CODE_BITS'(i_in_data.data_byte);
                    end else begin
                        hash_re = 1'b1;
                        n_slot  = f_hash(r_prefix, i_in_data.data_byte);
                        n_state = ST_PH;
                    end
                end
            end
            ST_PH: begin
                if (in_range) begin
                    node_re = 1'b1;
                    n_code  = r_hash_q;
                    n_state = ST_PN;
                end else begin
                    // empty slot: string not in dictionary
                    fin        = 1'b1;
                    res_miss   = 1'b1;
                    fin_last   = r_last;
                    new_prefix = CODE_BITS'(r_byte);
                    n_state    = ST_IDLE;
                end
            end
            ST_PN: begin
                if (genuine && key_match) begin
                    fin        = 1'b1;
                    fin_last   = r_last;
                    new_prefix = r_code;
                    n_state    = ST_IDLE;
                end else if (genuine) begin
                    // occupied by another string: linear probe
                    hash_re    = 1'b1;
                    hash_raddr = r_slot + HB'(1);
                    n_slot     = r_slot + HB'(1);
                    n_state    = ST_PH;
                end else begin
                    fin        = 1'b1;
                    res_miss   = 1'b1;
                    fin_last   = r_last;
                    new_prefix = CODE_BITS'(r_byte);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
        if (ins) begin
            hash_we = 1'b1;
            node_we = 1'b1;
        end
    end

    // Codes produced by a resolved byte
    always_comb begin
        p0    = '{code: CODE_W'(new_prefix), last_code: 1'b1};
        p1    = '{code: CODE_W'(new_prefix), last_code: 1'b1};
        npush = 2'd0;
        if (res_miss) begin
            p0    = '{code: CODE_W'(r_prefix), last_code: 1'b0};
            npush = fin_last ? 2'd2 : 2'd1;
        end else if (fin && fin_last) begin
            npush = 2'd1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_prefix    <= '0;
            r_present   <= 1'b0;
            r_next_free <= NF_BASE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (fin) begin
                if (fin_last) begin
                    r_prefix    <= '0;
                    r_present   <= 1'b0;
                    r_next_free <= NF_BASE;
                end else begin
                    r_prefix    <= new_prefix;
                    r_present   <= 1'b1;
                    r_next_free <= r_next_free + NFW'(ins);
                end
            end
            r_wp  <= r_wp + FIFO_AW'(npush);
            r_rp  <= r_rp + FIFO_AW'(pop);
            r_cnt <= r_cnt + CNT_W'(npush) - CNT_W'(pop);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_code <= n_code;
        if (acc) begin
            r_byte <= i_in_data.data_byte;
            r_last <= i_in_data.end_of_stream;
        end
        if (npush != 2'd0) begin
            r_fifo[r_wp] <= p0;
        end
        if (npush == 2'd2) begin
            r_fifo[r_wp + FIFO_AW'(1)] <= p1;
        end
    end

    // Hash index memory: slot -> code
    always_ff @(posedge i_clk) begin
        if (hash_we) begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        if (hash_re) begin
            r_hash_q <= hash_mem[hash_raddr];
        end
    end

    // Dictionary memory: code - 256 -> (prefix, byte, slot)
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            r_node_q <= node_mem[node_raddr];
        end
    end

    // Checks
    `LBC_ASSERT_ALWAYS(a_fifo_bound, r_cnt <= CNT_W'(FIFO_DEPTH), "output queue overflow")
    `LBC_ASSERT_ALWAYS(a_next_free_range, (r_next_free >= NF_BASE) && (r_next_free <= NF_LIMIT), "next free code out of range")
    `LBC_ASSERT_ALWAYS(a_probe_order, (r_state != ST_PN) || ($past(r_state) == ST_PH), "entry check without slot read")
    `LBC_ASSERT_NEXT(a_first_byte, acc && !r_present && !i_in_data.end_of_stream, r_present && (r_prefix == CODE_BITS'($past(i_in_data.data_byte))), "first byte not taken as prefix")

endmodule
